/* src/stb_pkg.sv */
package stb_pkg;

  // Most fire results reported for one input word.
  localparam int MAX_RESULTS = 16;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  typedef enum logic [2:0] {
    KIND_CREATE = 3'd0,
    KIND_DELETE = 3'd1,
    KIND_START  = 3'd2,
    KIND_STOP   = 3'd3,
    KIND_TICK   = 3'd4,
    KIND_POLL   = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    EV_DONE    = 3'd0,
    EV_CREATED = 3'd1,
    EV_FULL    = 3'd2,
    EV_FIRED   = 3'd3,
    EV_REJECT  = 3'd4
  } ev_code_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_LAST
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic walk;
    logic finish;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic walk_op;
    logic walk_end;
  } sts_t;

endpackage

/* src/stb_ram.sv */
module stb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/stb_ctrl.sv */
module stb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  stb_pkg::sts_t sts,
  output stb_pkg::cmd_t cmd
);

  stb_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      stb_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = stb_pkg::ST_EXEC;
        end
      end
      stb_pkg::ST_EXEC: begin
        state_nxt = sts.walk_op ? stb_pkg::ST_WALK : stb_pkg::ST_LAST;
      end
      stb_pkg::ST_WALK: begin
        if (sts.walk_end) begin
          state_nxt = stb_pkg::ST_LAST;
        end
      end
      stb_pkg::ST_LAST: begin
        state_nxt = stb_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = stb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      stb_pkg::ST_IDLE: cmd.load   = start;
      stb_pkg::ST_EXEC: cmd.exec   = 1'b1;
      stb_pkg::ST_WALK: cmd.walk   = 1'b1;
      stb_pkg::ST_LAST: cmd.finish = 1'b1;
      default:          cmd        = '0;
    endcase
  end

  assign busy = (state_r != stb_pkg::ST_IDLE);

endmodule

/* src/stb_dpath.sv */
module stb_dpath #(
  parameter int TIMER_SLOTS = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  stb_pkg::cmd_t cmd,
  output stb_pkg::sts_t sts,
  input  logic [2:0]    in_kind,
  input  logic [3:0]    in_slot,
  input  logic [31:0]   in_delay_ticks,
  input  logic          in_repeat_mode,
  input  logic          in_immediate_fire,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  output logic          out_strobe,
  output logic [2:0]    out_event_code,
  output logic [3:0]    out_timer_slot,
  output logic          out_last_of_run
);

  localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CW = COUNT_WIDTH;
  localparam int NW = stb_pkg::RES_CNT_W;

  // Latched input word.
  logic [2:0]    kind_r, kind_nxt;
  logic [3:0]    slot_r, slot_nxt;
  logic [CW-1:0] delay_r, delay_nxt;
  logic          rep_r, rep_nxt;
  logic          imm_r, imm_nxt;

  logic          ready_r, ready_nxt;

  // Per-slot flags, cleared by reset.
  logic [TIMER_SLOTS-1:0] used_r, used_nxt;
  logic [TIMER_SLOTS-1:0] mrep_r, mrep_nxt;
  logic [TIMER_SLOTS-1:0] mimm_r, mimm_nxt;
  logic [TIMER_SLOTS-1:0] run_r, run_nxt;
  logic [TIMER_SLOTS-1:0] pend_r, pend_nxt;

  logic [SW-1:0] idx_r, idx_nxt;
  logic [NW-1:0] n_r, n_nxt;

  // One-deep hold stage: a result waits here until it is known whether
  // another one follows, which decides its last_of_run bit.
  logic                hold_vld_r, hold_vld_nxt;
  stb_pkg::ev_code_t   hold_code_r, hold_code_nxt;
  logic [3:0]          hold_slot_r, hold_slot_nxt;

  logic                out_strobe_r, out_strobe_nxt;
  stb_pkg::ev_code_t   out_code_r, out_code_nxt;
  logic [3:0]          out_slot_r, out_slot_nxt;
  logic                out_last_r, out_last_nxt;

  // Count and reload memories.
  logic          cnt_we;
  logic [SW-1:0] cnt_waddr;
  logic [CW-1:0] cnt_wdata;
  logic [SW-1:0] rd_addr;
  logic [CW-1:0] cnt_rd;
  logic          rld_we;
  logic [CW-1:0] rld_rd;

  logic [63:0]   delay_ext;
  logic [7:0]    slot_ext;
  logic [7:0]    idx_ext;
  logic [SW-1:0] slot_idx;
  logic [3:0]    idx_slot;
  logic          in_bank;
  logic          walk_last;
  logic          create_hit;
  logic          emit_new;
  logic [CW-1:0] cnt_dec;
  logic          start_ok;

  assign delay_ext = {32'b0, in_delay_ticks};
  assign slot_ext  = {4'b0, slot_r};
  assign idx_ext   = {{(8 - SW){1'b0}}, idx_r};
  assign slot_idx  = slot_ext[SW-1:0];
  assign idx_slot  = idx_ext[3:0];
  assign in_bank   = ({3'b000, slot_r} < 7'(TIMER_SLOTS));
  assign walk_last = (idx_r == SW'(TIMER_SLOTS - 1));
  assign cnt_dec   = cnt_rd - CW'(1);

  assign create_hit = (kind_r == stb_pkg::KIND_CREATE) && ready_r && !used_r[idx_r];
  assign start_ok   = in_bank && used_r[slot_idx] && (delay_r != '0);

  assign sts.walk_op  = kind_r inside {stb_pkg::KIND_CREATE, stb_pkg::KIND_TICK,
                                       stb_pkg::KIND_POLL};
  assign sts.walk_end = walk_last || create_hit;

  // The read for slot i+1 is issued while slot i is processed.
  assign rd_addr = (cmd.walk && !walk_last) ? SW'(idx_r + SW'(1)) : '0;

  always_comb begin
    kind_nxt      = kind_r;
    slot_nxt      = slot_r;
    delay_nxt     = delay_r;
    rep_nxt       = rep_r;
    imm_nxt       = imm_r;
    ready_nxt     = ready_r;
    used_nxt      = used_r;
    mrep_nxt      = mrep_r;
    mimm_nxt      = mimm_r;
    run_nxt       = run_r;
    pend_nxt      = pend_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    hold_vld_nxt  = hold_vld_r;
    hold_code_nxt = hold_code_r;
    hold_slot_nxt = hold_slot_r;
    out_strobe_nxt = 1'b0;
    out_code_nxt   = out_code_r;
    out_slot_nxt   = out_slot_r;
    out_last_nxt   = out_last_r;
    cnt_we    = 1'b0;
    cnt_waddr = idx_r;
    cnt_wdata = cnt_dec;
    rld_we    = 1'b0;
    emit_new  = 1'b0;

    if (cfg_we) begin
      ready_nxt = cfg_wdata;
    end

    if (cmd.load) begin
      kind_nxt     = in_kind;
      slot_nxt     = in_slot;
      delay_nxt    = delay_ext[CW-1:0];
      rep_nxt      = in_repeat_mode;
      imm_nxt      = in_immediate_fire;
      idx_nxt      = '0;
      n_nxt        = '0;
      hold_vld_nxt = 1'b0;
    end

    if (cmd.exec) begin
      hold_slot_nxt = 4'd0;
      case (kind_r)
        stb_pkg::KIND_CREATE: begin
          // Stays as the answer unless the walk finds a free slot.
          hold_vld_nxt  = 1'b1;
          hold_code_nxt = stb_pkg::EV_FULL;
        end
        stb_pkg::KIND_DELETE: begin
          hold_vld_nxt  = 1'b1;
          hold_code_nxt = in_bank ? stb_pkg::EV_DONE : stb_pkg::EV_REJECT;
          if (in_bank && used_r[slot_idx]) begin
            used_nxt[slot_idx] = 1'b0;
            mrep_nxt[slot_idx] = 1'b0;
            mimm_nxt[slot_idx] = 1'b0;
            run_nxt[slot_idx]  = 1'b0;
            pend_nxt[slot_idx] = 1'b0;
          end
        end
        stb_pkg::KIND_STOP: begin
          hold_vld_nxt  = 1'b1;
          hold_code_nxt = in_bank ? stb_pkg::EV_DONE : stb_pkg::EV_REJECT;
          if (in_bank) begin
            run_nxt[slot_idx]  = 1'b0;
            pend_nxt[slot_idx] = 1'b0;
          end
        end
        stb_pkg::KIND_START: begin
          hold_vld_nxt  = 1'b1;
          hold_code_nxt = start_ok ? stb_pkg::EV_DONE : stb_pkg::EV_REJECT;
          if (start_ok) begin
            cnt_we             = 1'b1;
            cnt_waddr          = slot_idx;
            cnt_wdata          = delay_r;
            rld_we             = 1'b1;
            run_nxt[slot_idx]  = 1'b1;
            pend_nxt[slot_idx] = 1'b0;
          end
        end
        stb_pkg::KIND_TICK, stb_pkg::KIND_POLL: begin
          hold_vld_nxt = 1'b0;
        end
        default: begin
          hold_vld_nxt  = 1'b1;
          hold_code_nxt = stb_pkg::EV_REJECT;
        end
      endcase
    end

    if (cmd.walk) begin
      idx_nxt = SW'(idx_r + SW'(1));
      case (kind_r)
        stb_pkg::KIND_CREATE: begin
          if (create_hit) begin
            used_nxt[idx_r] = 1'b1;
            mrep_nxt[idx_r] = rep_r;
            mimm_nxt[idx_r] = imm_r;
            run_nxt[idx_r]  = 1'b0;
            pend_nxt[idx_r] = 1'b0;
            hold_code_nxt   = stb_pkg::EV_CREATED;
            hold_slot_nxt   = idx_slot;
          end
        end
        stb_pkg::KIND_TICK: begin
          if (used_r[idx_r] && run_r[idx_r]) begin
            cnt_we = 1'b1;
            if (cnt_dec == '0) begin
              if (mimm_r[idx_r] && (n_r < NW'(stb_pkg::MAX_RESULTS))) begin
                emit_new = 1'b1;
              end else begin
                pend_nxt[idx_r] = 1'b1;
              end
              if (mrep_r[idx_r]) begin
                cnt_wdata = rld_rd;
              end else begin
                run_nxt[idx_r] = 1'b0;
              end
            end
          end
        end
        stb_pkg::KIND_POLL: begin
          if (used_r[idx_r] && pend_r[idx_r] && (n_r < NW'(stb_pkg::MAX_RESULTS))) begin
            pend_nxt[idx_r] = 1'b0;
            emit_new        = 1'b1;
          end
        end
        default: begin
          emit_new = 1'b0;
        end
      endcase
    end

    if (emit_new) begin
      n_nxt = NW'(n_r + NW'(1));
      if (hold_vld_r) begin
        out_strobe_nxt = 1'b1;
        out_code_nxt   = hold_code_r;
        out_slot_nxt   = hold_slot_r;
        out_last_nxt   = 1'b0;
      end
      hold_vld_nxt  = 1'b1;
      hold_code_nxt = stb_pkg::EV_FIRED;
      hold_slot_nxt = idx_slot;
    end

    if (cmd.finish) begin
      out_strobe_nxt = 1'b1;
      out_code_nxt   = hold_vld_r ? hold_code_r : stb_pkg::EV_DONE;
      out_slot_nxt   = hold_vld_r ? hold_slot_r : 4'd0;
      out_last_nxt   = 1'b1;
      hold_vld_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r      <= 1'b0;
      used_r       <= '0;
      mrep_r       <= '0;
      mimm_r       <= '0;
      run_r        <= '0;
      pend_r       <= '0;
      hold_vld_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      ready_r      <= ready_nxt;
      used_r       <= used_nxt;
      mrep_r       <= mrep_nxt;
      mimm_r       <= mimm_nxt;
      run_r        <= run_nxt;
      pend_r       <= pend_nxt;
      hold_vld_r   <= hold_vld_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    slot_r      <= slot_nxt;
    delay_r     <= delay_nxt;
    rep_r       <= rep_nxt;
    imm_r       <= imm_nxt;
    idx_r       <= idx_nxt;
    n_r         <= n_nxt;
    hold_code_r <= hold_code_nxt;
    hold_slot_r <= hold_slot_nxt;
    out_code_r  <= out_code_nxt;
    out_slot_r  <= out_slot_nxt;
    out_last_r  <= out_last_nxt;
  end

  stb_ram #(
    .WIDTH (CW),
    .DEPTH (TIMER_SLOTS)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (rd_addr),
    .rdata (cnt_rd)
  );

  stb_ram #(
    .WIDTH (CW),
    .DEPTH (TIMER_SLOTS)
  ) u_reload_ram (
    .clk   (clk),
    .we    (rld_we),
    .waddr (slot_idx),
    .wdata (delay_r),
    .raddr (rd_addr),
    .rdata (rld_rd)
  );

  assign out_strobe      = out_strobe_r;
  assign out_event_code  = out_code_r;
  assign out_timer_slot  = out_slot_r;
  assign out_last_of_run = out_last_r;

endmodule

/* src/software_timer_bank_unit.sv */
// Bank of countdown timer slots driven by command words.
// Input channel: a command word (in_kind, in_slot, in_delay_ticks, in_repeat_mode,
// in_immediate_fire) is taken at a rising edge where start is high and busy is low.
// Kinds are create, delete, start, stop, tick and poll; other codes are rejected.
// Result channel: each result word is shown for one cycle with out_strobe high;
// out_last_of_run marks the final word of a command. The receiver cannot stall
// the block, so every result is taken in the cycle it is shown.
// Configuration: cfg_we writes cfg_wdata into the module-ready bit; creates
// fail while it is clear. Write it only while the block is idle.
// Sequencing: delete, start, stop and unknown kinds pass the execute and final-result
// states and show their single result in the cycle where busy falls. Tick and poll walk
// all TIMER_SLOTS slots one per cycle through the count memory's single read port;
// a create stops its walk at the first free slot. Fire results leave in ascending
// slot order, at most one per cycle, and the final word of a command always shows
// in the cycle where busy falls.
// Reset (rst_n low, synchronous) frees every slot, clears the module-ready bit
// and drops any command in progress; count memories need no clearing pass.
module software_timer_bank_unit #(
  parameter int TIMER_SLOTS = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_kind,
  input  logic [3:0]  in_slot,
  input  logic [31:0] in_delay_ticks,
  input  logic        in_repeat_mode,
  input  logic        in_immediate_fire,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  output logic        out_strobe,
  output logic [2:0]  out_event_code,
  output logic [3:0]  out_timer_slot,
  output logic        out_last_of_run
);

  // The controller sequences each command through execute, slot walk and
  // final-result steps; the datapath owns all slot state and the memories.
  stb_pkg::cmd_t cmd;
  stb_pkg::sts_t sts;

  stb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  stb_dpath #(
    .TIMER_SLOTS (TIMER_SLOTS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_kind           (in_kind),
    .in_slot           (in_slot),
    .in_delay_ticks    (in_delay_ticks),
    .in_repeat_mode    (in_repeat_mode),
    .in_immediate_fire (in_immediate_fire),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_strobe        (out_strobe),
    .out_event_code    (out_event_code),
    .out_timer_slot    (out_timer_slot),
    .out_last_of_run   (out_last_of_run)
  );

endmodule

/* src/stb_checker.sv */
module stb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_strobe,
  input logic [2:0] out_event_code,
  input logic       out_last_of_run
);

  // An accepted command keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  // Only fire results can be followed by more results of the same command.
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_event_code != stb_pkg::EV_FIRED) |-> out_last_of_run)
    else $error("non-fire result not marked last");

  // Busy drops exactly when the final result of a command is shown.
  a_end_of_run: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_strobe && out_last_of_run)
    else $error("busy fell without a final result");

  // No result directly follows the final one of a command.
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last_of_run |=> !out_strobe)
    else $error("result shown right after final result");

endmodule

bind software_timer_bank_unit stb_checker u_stb_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_strobe      (out_strobe),
  .out_event_code  (out_event_code),
  .out_last_of_run (out_last_of_run)
);
